// ----- hw/rtl/wsei_pkg.sv -----
package wsei_pkg;

  // Field widths of the input and result words.
  localparam int CountBits = 32;
  localparam int TimeBits  = 32;
  localparam int SpeedBits = 32;
  localparam int FanBits   = 16;
  localparam int FracBits  = 16;

  localparam int InDataBits  = 2 * CountBits + TimeBits;
  localparam int OutDataBits = 2 * SpeedBits + FanBits;

  // Configuration port.
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 20;
  localparam int ScaleBits   = 20;
  localparam int CoefBits    = 16;

  localparam logic [CfgIdxBits-1:0] RegCountScale  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegFiltB       = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegFiltA       = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegWheelRadius = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegFanBase     = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegFanGain     = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegFanMax      = 3'd6;

  localparam logic [ScaleBits-1:0] CountScaleRst  = 20'd96963;
  localparam logic [CoefBits-1:0]  FiltBRst       = 16'd7350;
  localparam logic [CoefBits-1:0]  FiltARst       = 16'd50835;
  localparam logic [CoefBits-1:0]  WheelRadiusRst = 16'd662;
  localparam logic [CoefBits-1:0]  FanBaseRst     = 16'd1400;
  localparam logic [CoefBits-1:0]  FanGainRst     = 16'd350;
  localparam logic [CoefBits-1:0]  FanMaxRst      = 16'd1700;

  // Saturation limits of a Q16.16 speed, as magnitudes.
  localparam logic [SpeedBits-1:0] PosMax    = 32'h7FFF_FFFF;
  localparam logic [SpeedBits-1:0] NegMinMag = 32'h8000_0000;

endpackage

// ----- hw/rtl/wsei_div.sv -----
module wsei_div #(
  parameter int DivBits = wsei_pkg::TimeBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivBits-1:0] num_hi_i,
  input  logic [DivBits-1:0] num_lo_i,
  input  logic [DivBits-1:0] den_i,
  output logic               done_o,
  output logic [DivBits-1:0] quot_o
);

  localparam int CntBits = $clog2(DivBits);
  localparam logic [CntBits-1:0] LastStep = CntBits'(DivBits - 1);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [DivBits-1:0] rem_q;
  logic [DivBits-1:0] shift_q;
  logic [DivBits-1:0] den_q;

  logic [DivBits:0] trial;
  logic [DivBits:0] diff;
  logic             ge;

  // One restoring step a cycle. The remainder stays below the divisor, so the
  // upper half of the dividend must already be below it when started.
  assign trial = {rem_q, shift_q[DivBits-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= num_hi_i;
      shift_q <= num_lo_i;
      den_q   <= den_i;
    end else if (busy_q) begin
      rem_q   <= ge ? diff[DivBits-1:0] : trial[DivBits-1:0];
      shift_q <= {shift_q[DivBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = shift_q;

endmodule

// ----- hw/rtl/wheel_speed_estimator_iir_top.sv -----
// Wheel speed estimator with first-order smoothing and a fan command.
// The slave stream takes one word per sample tick: both wheels' encoder
// counts and a microsecond timestamp. The master stream returns one word per
// input word: both filtered wheel speeds in signed Q16.16 and the fan pulse.
// Registers are written over the cfg channel, which is always ready; write
// them only while no word is in flight.
// Words are handled one at a time by a single sequencer that shares one
// 33x33 multiplier and one bit-serial divider between both wheels. A wheel
// whose count did not change passes only the delta step; a changed wheel
// goes on through the scale, divider check, divider wait and filter steps,
// skipping the divider wait when the quotient overflows. The fan steps follow;
// the block is ready again in the cycle after the result is loaded.
// The result sits in an output register, so the block is ready for the next
// word while the receiver holds it. A finished word waits in the last
// sequencer step until the output register is free.
// Reset restores the register defaults and clears all wheel history.
module wheel_speed_estimator_iir_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // left_count [31:0], right_count [63:32], time_us [95:64]
  input  logic [wsei_pkg::InDataBits-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // left_speed [31:0], right_speed [63:32], fan_pulse [79:64]
  output logic [wsei_pkg::OutDataBits-1:0] m_axis_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wsei_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [wsei_pkg::CfgDataBits-1:0] cfg_data_i
);

  import wsei_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DELTA   = 4'd1;
  localparam logic [3:0] ST_SCALE   = 4'd2;
  localparam logic [3:0] ST_DIVCHK  = 4'd3;
  localparam logic [3:0] ST_DIVWAIT = 4'd4;
  localparam logic [3:0] ST_FILTB   = 4'd5;
  localparam logic [3:0] ST_FILTA   = 4'd6;
  localparam logic [3:0] ST_FILTY   = 4'd7;
  localparam logic [3:0] ST_FANR    = 4'd8;
  localparam logic [3:0] ST_FANS    = 4'd9;
  localparam logic [3:0] ST_FANSQ   = 4'd10;
  localparam logic [3:0] ST_FANLO   = 4'd11;
  localparam logic [3:0] ST_FANHI   = 4'd12;
  localparam logic [3:0] ST_FANSUM  = 4'd13;
  localparam logic [3:0] ST_FANCAP  = 4'd14;

  // Configuration registers.
  logic [ScaleBits-1:0] count_scale_q;
  logic [CoefBits-1:0]  filt_b_q;
  logic [CoefBits-1:0]  filt_a_q;
  logic [CoefBits-1:0]  wheel_radius_q;
  logic [CoefBits-1:0]  fan_base_q;
  logic [CoefBits-1:0]  fan_gain_q;
  logic [CoefBits-1:0]  fan_max_q;

  // Wheel history, entry 0 is the left wheel.
  logic [CountBits-1:0] last_count_q [2];
  logic [TimeBits-1:0]  change_time_q [2];
  logic [SpeedBits-1:0] prev_raw_q [2];
  logic [SpeedBits-1:0] prev_filt_q [2];

  logic [3:0]           state_q;
  logic                 wsel_q;
  logic                 out_valid_q;

  logic [CountBits-1:0] cnt_l_q;
  logic [CountBits-1:0] cnt_r_q;
  logic [TimeBits-1:0]  time_q;
  logic                 neg_q;
  logic [CountBits-1:0] dmag_q;
  logic [TimeBits-1:0]  elapsed_q;
  logic [SpeedBits-1:0] raw_q;
  logic [SpeedBits-1:0] speed_q [2];
  logic [65:0]          prod_q;
  logic [50:0]          acc_q;
  logic [31:0]          lin_q;
  logic [31:0]          sq_hi_q;
  logic [OutDataBits-1:0] out_data_q;

  logic                 in_acc;
  logic [CountBits-1:0] cnt_sel;
  logic [CountBits-1:0] delta;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;
  logic [SpeedBits-1:0] quot_lim;
  logic [SpeedBits-1:0] quot_mag;
  logic signed [50:0]   filt_sum;
  logic signed [34:0]   filt_y;
  logic [SpeedBits-1:0] filt_sat;
  logic [65:0]          prod_abs;
  logic [50:0]          fan_sum;
  logic [FanBits-1:0]   fan_cap;
  logic                 div_start;
  logic                 div_done;
  logic [TimeBits-1:0]  div_quot;
  logic                 div_ovf;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign cnt_sel = wsel_q ? cnt_r_q : cnt_l_q;
  assign delta   = cnt_sel - last_count_q[wsel_q];

  // The quotient needs more than 32 bits exactly when the upper half of the
  // scaled dividend reaches the interval; a zero interval lands here too.
  assign div_ovf   = (prod_q[51:FracBits] >= {4'b0, elapsed_q});
  assign div_start = (state_q == ST_DIVCHK) && !div_ovf;

  assign quot_lim = neg_q ? NegMinMag : PosMax;
  assign quot_mag = (div_quot > quot_lim) ? quot_lim : div_quot;

  assign filt_sum = $signed(acc_q) + $signed(prod_q[50:0]);
  assign filt_y   = 35'(filt_sum >>> FracBits);
  always_comb begin
    if (filt_y > $signed({3'b0, PosMax})) begin
      filt_sat = PosMax;
    end else if (filt_y < -$signed({3'b0, NegMinMag})) begin
      filt_sat = NegMinMag;
    end else begin
      filt_sat = filt_y[SpeedBits-1:0];
    end
  end

  assign prod_abs = prod_q[65] ? (~prod_q + 66'd1) : prod_q;
  assign fan_sum  = {3'b0, prod_q[47:0]} + {35'b0, acc_q[47:32]} + {35'b0, fan_base_q};
  assign fan_cap  = (acc_q > {35'b0, fan_max_q}) ? fan_max_q : acc_q[FanBits-1:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SCALE: begin
        mul_a = {1'b0, dmag_q};
        mul_b = {13'b0, count_scale_q};
      end
      ST_FILTB: begin
        mul_a = {raw_q[31], raw_q} + {prev_raw_q[wsel_q][31], prev_raw_q[wsel_q]};
        mul_b = {17'b0, filt_b_q};
      end
      ST_FILTA: begin
        mul_a = {prev_filt_q[wsel_q][31], prev_filt_q[wsel_q]};
        mul_b = {17'b0, filt_a_q};
      end
      ST_FANR: begin
        mul_a = {speed_q[0][31], speed_q[0]} + {speed_q[1][31], speed_q[1]};
        mul_b = {17'b0, wheel_radius_q};
      end
      ST_FANSQ: begin
        mul_a = {1'b0, lin_q};
        mul_b = {1'b0, lin_q};
      end
      ST_FANLO: begin
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {17'b0, fan_gain_q};
      end
      ST_FANHI: begin
        mul_a = {1'b0, sq_hi_q};
        mul_b = {17'b0, fan_gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  wsei_div #(
    .DivBits (TimeBits)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (prod_q[47:FracBits]),
    .num_lo_i ({prod_q[FracBits-1:0], {FracBits{1'b0}}}),
    .den_i    (elapsed_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_scale_q  <= CountScaleRst;
      filt_b_q       <= FiltBRst;
      filt_a_q       <= FiltARst;
      wheel_radius_q <= WheelRadiusRst;
      fan_base_q     <= FanBaseRst;
      fan_gain_q     <= FanGainRst;
      fan_max_q      <= FanMaxRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegCountScale:  count_scale_q  <= cfg_data_i[ScaleBits-1:0];
        RegFiltB:       filt_b_q       <= cfg_data_i[CoefBits-1:0];
        RegFiltA:       filt_a_q       <= cfg_data_i[CoefBits-1:0];
        RegWheelRadius: wheel_radius_q <= cfg_data_i[CoefBits-1:0];
        RegFanBase:     fan_base_q     <= cfg_data_i[CoefBits-1:0];
        RegFanGain:     fan_gain_q     <= cfg_data_i[CoefBits-1:0];
        RegFanMax:      fan_max_q      <= cfg_data_i[CoefBits-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and wheel history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wsel_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      last_count_q  <= '{default: '0};
      change_time_q <= '{default: '0};
      prev_raw_q    <= '{default: '0};
      prev_filt_q   <= '{default: '0};
    end else begin
      if ((state_q == ST_FANCAP) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            wsel_q  <= 1'b0;
            state_q <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          last_count_q[wsel_q] <= cnt_sel;
          if (delta == '0) begin
            // An unchanged wheel reports zero and keeps its history.
            wsel_q  <= 1'b1;
            state_q <= wsel_q ? ST_FANR : ST_DELTA;
          end else begin
            change_time_q[wsel_q] <= time_q;
            state_q               <= ST_SCALE;
          end
        end
        ST_SCALE:  state_q <= ST_DIVCHK;
        ST_DIVCHK: state_q <= div_ovf ? ST_FILTB : ST_DIVWAIT;
        ST_DIVWAIT: begin
          if (div_done) begin
            state_q <= ST_FILTB;
          end
        end
        ST_FILTB: state_q <= ST_FILTA;
        ST_FILTA: state_q <= ST_FILTY;
        ST_FILTY: begin
          prev_raw_q[wsel_q]  <= raw_q;
          prev_filt_q[wsel_q] <= filt_sat;
          wsel_q              <= 1'b1;
          state_q             <= wsel_q ? ST_FANR : ST_DELTA;
        end
        ST_FANR:   state_q <= ST_FANS;
        ST_FANS:   state_q <= ST_FANSQ;
        ST_FANSQ:  state_q <= ST_FANLO;
        ST_FANLO:  state_q <= ST_FANHI;
        ST_FANHI:  state_q <= ST_FANSUM;
        ST_FANSUM: state_q <= ST_FANCAP;
        ST_FANCAP: begin
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      cnt_l_q <= s_axis_tdata_i[CountBits-1:0];
      cnt_r_q <= s_axis_tdata_i[2*CountBits-1:CountBits];
      time_q  <= s_axis_tdata_i[InDataBits-1:2*CountBits];
    end
    case (state_q)
      ST_DELTA: begin
        neg_q     <= delta[CountBits-1];
        dmag_q    <= delta[CountBits-1] ? (~delta + 1'b1) : delta;
        elapsed_q <= time_q - change_time_q[wsel_q];
        if (delta == '0) begin
          speed_q[wsel_q] <= '0;
        end
      end
      ST_DIVCHK: begin
        if (div_ovf) begin
          raw_q <= neg_q ? NegMinMag : PosMax;
        end
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          raw_q <= neg_q ? (~quot_mag + 1'b1) : quot_mag;
        end
      end
      ST_FILTA:  acc_q <= prod_q[50:0];
      ST_FILTY:  speed_q[wsel_q] <= filt_sat;
      ST_FANS:   lin_q <= prod_abs[48:17];
      ST_FANLO:  sq_hi_q <= prod_q[63:32];
      ST_FANHI:  acc_q <= prod_q[50:0];
      ST_FANSUM: acc_q <= fan_sum;
      ST_FANCAP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_q <= {fan_cap, speed_q[1], speed_q[0]};
        end
      end
      default: ;
    endcase
  end

  // An accepted word always starts with the left wheel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DELTA) && !wsel_q)
    else $error("sample did not start with the left wheel");

  // A new result only appears out of the final sequencer step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_FANCAP)
    else $error("result loaded outside the fan step");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVWAIT)
    else $error("divider finished outside its wait step");

  // A finished word waits while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FANCAP) && out_valid_q && !m_axis_tready_i |=> state_q == ST_FANCAP)
    else $error("result dropped while output stalled");

endmodule

// ----- verif/wheel_speed_estimator_iir_top_tb.sv -----
module wheel_speed_estimator_iir_top_tb;
  import wsei_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int CycleLimit = 1_000_000;
  localparam int PhaseItems = 270;
  localparam int MaxReports = 10;
  localparam logic [CfgIdxBits-1:0] RegNone = 3'd7;

  typedef struct packed {
    logic [FanBits-1:0]          fan_pulse;
    logic signed [SpeedBits-1:0] right_speed;
    logic signed [SpeedBits-1:0] left_speed;
  } speed_word_t;

  typedef struct {
    logic [CountBits-1:0] last_cnt;
    logic [TimeBits-1:0]  chg_time;
    logic signed [63:0]   prev_raw;
    logic signed [63:0]   prev_out;
  } wheel_hist_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] idx;
    logic [CfgDataBits-1:0] val;
    logic [CountBits-1:0]  lc;
    logic [CountBits-1:0]  rc;
    logic [TimeBits-1:0]   t;
    bit                    typed;
    speed_word_t           want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [InDataBits-1:0]  s_data = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b1;
  logic [OutDataBits-1:0] m_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  // Register mirror and wheel history of the speed model.
  logic [ScaleBits-1:0] m_scale;
  logic [CoefBits-1:0]  m_b, m_a, m_radius, m_base, m_gain, m_max;
  wheel_hist_t          hist [2];

  speed_word_t pending_q [$];
  dir_row_t    dir_rows [$];
  logic [31:0] cur_l, cur_r, cur_t;
  bit          idling = 1'b1;
  int          stall_left = 0;
  int          cycles = 0;
  int          mismatches = 0;
  int          checked = 0;
  int          saturated = 0;
  int          sent = 0;
  int          settings = 1;

  wheel_speed_estimator_iir_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic logic signed [31:0] wheel_speed(input int w, input logic [31:0] cnt,
                                                     input logic [31:0] t);
    logic [31:0] d, dmag, el, lim;
    logic neg;
    logic [63:0] num, m;
    logic [127:0] q;
    logic signed [63:0] x, acc, y, coef_b, coef_a;
    d = cnt - hist[w].last_cnt;
    hist[w].last_cnt = cnt;
    if (d == 0) return '0;
    neg = d[31];
    dmag = neg ? -d : d;
    el = t - hist[w].chg_time;
    hist[w].chg_time = t;
    lim = neg ? NegMinMag : PosMax;
    if (el == 0) begin
      m = {32'b0, lim};
    end else begin
      num = {44'b0, m_scale} * {32'b0, dmag};
      q = {64'b0, num} / {96'b0, el};
      if (q >= 128'h8000_0000) begin
        m = {32'b0, lim};
      end else begin
        q = ({64'b0, num} << 16) / {96'b0, el};
        m = (q > {96'b0, lim}) ? {32'b0, lim} : q[63:0];
      end
    end
    x = neg ? -$signed(m) : $signed(m);
    coef_b = $signed({48'b0, m_b});
    coef_a = $signed({48'b0, m_a});
    acc = coef_b * (x + hist[w].prev_raw) + coef_a * hist[w].prev_out;
    // An arithmetic shift rounds toward minus infinity, as the filter requires.
    y = acc >>> 16;
    if (y > $signed(64'(PosMax))) y = $signed(64'(PosMax));
    if (y < -$signed(64'(NegMinMag))) y = -$signed(64'(NegMinMag));
    hist[w].prev_raw = x;
    hist[w].prev_out = y;
    return y[31:0];
  endfunction

  function automatic speed_word_t estimate(input logic [31:0] lc, input logic [31:0] rc,
                                           input logic [31:0] t);
    speed_word_t word;
    logic signed [63:0] sum;
    logic [63:0] v;
    logic [127:0] s, term, fan;
    word.left_speed = wheel_speed(0, lc, t);
    word.right_speed = wheel_speed(1, rc, t);
    sum = {{32{word.left_speed[31]}}, word.left_speed}
        + {{32{word.right_speed[31]}}, word.right_speed};
    v = sum[63] ? -sum : sum;
    s = ({112'b0, m_radius} * {64'b0, v}) >> 17;
    term = ({112'b0, m_gain} * (s * s)) >> 32;
    fan = {112'b0, m_base} + term;
    word.fan_pulse = (fan > {112'b0, m_max}) ? m_max : fan[15:0];
    return word;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxBits-1:0] idx,
                                    input logic [CfgDataBits-1:0] data);
    case (idx)
      RegCountScale:  m_scale = data;
      RegFiltB:       m_b = data[15:0];
      RegFiltA:       m_a = data[15:0];
      RegWheelRadius: m_radius = data[15:0];
      RegFanBase:     m_base = data[15:0];
      RegFanGain:     m_gain = data[15:0];
      RegFanMax:      m_max = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic dir_row_t smp(input logic [31:0] lc, input logic [31:0] rc,
                                   input logic [31:0] t);
    dir_row_t row;
    row = '{kind: RowSample, idx: '0, val: '0, lc: lc, rc: rc, t: t, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic dir_row_t smp_known(input logic [31:0] lc, input logic [31:0] rc,
                                         input logic [31:0] t, input logic [15:0] fan);
    dir_row_t row;
    row = smp(lc, rc, t);
    row.typed = 1'b1;
    row.want = '{fan_pulse: fan, right_speed: '0, left_speed: '0};
    return row;
  endfunction

  function automatic dir_row_t wr(input logic [CfgIdxBits-1:0] idx,
                                  input logic [CfgDataBits-1:0] val);
    dir_row_t row;
    row = smp('0, '0, '0);
    row.kind = RowWrite;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("Mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc,
                             input logic [31:0] t, input bit typed,
                             input speed_word_t want);
    int unsigned gap;
    speed_word_t word;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {t, rc, lc};
    do @(posedge clk_i); while (!s_ready);
    word = estimate(lc, rc, t);
    pending_q.push_back(typed ? want : word);
    sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [19:0] scale, input logic [15:0] b,
                          input logic [15:0] a, input logic [15:0] radius,
                          input logic [15:0] base, input logic [15:0] gain,
                          input logic [15:0] max_pulse);
    // The spare upper bits of the 16-bit registers carry noise that must be dropped.
    wait_drain();
    write_reg(RegCountScale, scale);
    write_reg(RegFiltB, {4'($urandom), b});
    write_reg(RegFiltA, {4'($urandom), a});
    write_reg(RegWheelRadius, {4'($urandom), radius});
    write_reg(RegFanBase, {4'($urandom), base});
    write_reg(RegFanGain, {4'($urandom), gain});
    write_reg(RegFanMax, {4'($urandom), max_pulse});
    settings++;
  endtask

  task automatic run_phase(input int n_items);
    int pause_at;
    int unsigned kind;
    pause_at = $urandom_range(10, n_items - 10);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_drain();
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // Plausible motion: small count steps, some ticks without a change.
        if (kind < 70) cur_t = cur_t + $urandom_range(1, 20000);
        if ($urandom_range(0, 3) != 0) cur_l = cur_l + 32'($urandom_range(0, 600)) - 32'd300;
        if ($urandom_range(0, 3) != 0) cur_r = cur_r + 32'($urandom_range(0, 600)) - 32'd300;
      end else if (kind < 90) begin
        cur_l = $urandom;
        cur_r = $urandom;
        cur_t = $urandom;
      end else begin
        cur_l = cur_l + $urandom;
        cur_r = cur_r - $urandom_range(0, 70000);
        cur_t = cur_t + $urandom_range(0, 200);
      end
      send_sample(cur_l, cur_r, cur_t, 1'b0, '0);
    end
  endtask

  // Result side: random stall bursts while idling is on.
  always @(negedge clk_i) begin
    if (!idling) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    speed_word_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      checked++;
      if (got.left_speed == PosMax || got.left_speed == NegMinMag) saturated++;
      if (got.right_speed == PosMax || got.right_speed == NegMinMag) saturated++;
      if (pending_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got.left_speed);
      end else begin
        want = pending_q.pop_front();
        if (got.left_speed !== want.left_speed)
          note_mismatch("left_speed", want.left_speed, got.left_speed);
        if (got.right_speed !== want.right_speed)
          note_mismatch("right_speed", want.right_speed, got.right_speed);
        if (got.fan_pulse !== want.fan_pulse)
          note_mismatch("fan_pulse", 32'(want.fan_pulse), 32'(got.fan_pulse));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               pending_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    m_scale = CountScaleRst;
    m_b = FiltBRst;
    m_a = FiltARst;
    m_radius = WheelRadiusRst;
    m_base = FanBaseRst;
    m_gain = FanGainRst;
    m_max = FanMaxRst;
    for (int w = 0; w < 2; w++) hist[w] = '{last_cnt: '0, chg_time: '0, prev_raw: 0, prev_out: 0};

    // Directed part: extremes of counts and time, zero interval, wraps, cap and
    // register extremes.
    dir_rows.push_back(smp_known(32'h0, 32'h0, 32'd100, 16'd1400));
    dir_rows.push_back(smp(32'h1, 32'hFFFF_FFFF, 32'd100));
    dir_rows.push_back(smp_known(32'h1, 32'hFFFF_FFFF, 32'd150, 16'd1400));
    dir_rows.push_back(smp(32'h2, 32'hFFFF_FFFE, 32'd100));
    dir_rows.push_back(smp(32'h7FFF_FFFF, 32'h8000_0000, 32'd5000));
    dir_rows.push_back(smp(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(smp_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h10, 16'd1400));
    dir_rows.push_back(smp(32'h8000_0010, 32'h7FFF_FFF0, 32'h20));
    dir_rows.push_back(smp(32'h0000_0010, 32'h7FFF_FFF0, 32'h1000));
    dir_rows.push_back(smp(32'h0000_0011, 32'h7FFF_FFF0, 32'h8000_1000));
    dir_rows.push_back(wr(RegFanBase, 20'd2000));
    dir_rows.push_back(smp_known(32'h11, 32'h7FFF_FFF0, 32'h9000_0000, 16'd1700));
    dir_rows.push_back(wr(RegFanBase, 20'd1400));
    dir_rows.push_back(wr(RegNone, 20'hF_FFFF));
    dir_rows.push_back(smp_known(32'h11, 32'h7FFF_FFF0, 32'h0, 16'd1400));
    dir_rows.push_back(wr(RegCountScale, 20'd0));
    dir_rows.push_back(smp(32'h16, 32'h7FFF_FFEB, 32'h8000_2000));
    dir_rows.push_back(wr(RegCountScale, 20'hF_FFFF));
    dir_rows.push_back(wr(RegFiltB, 20'hF_FFFF));
    dir_rows.push_back(wr(RegFiltA, 20'hF_FFFF));
    dir_rows.push_back(wr(RegWheelRadius, 20'hF_FFFF));
    dir_rows.push_back(wr(RegFanGain, 20'hF_FFFF));
    dir_rows.push_back(wr(RegFanMax, 20'hF_FFFF));
    dir_rows.push_back(smp(32'h000F_4256, 32'h800F_422B, 32'h8000_2001));
    dir_rows.push_back(smp(32'h000F_4255, 32'h800F_422C, 32'h8000_2400));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == RowWrite) begin
        wait_drain();
        write_reg(row.idx, row.val);
      end else begin
        send_sample(row.lc, row.rc, row.t, row.typed, row.want);
      end
    end
    cur_l = 32'h000F_4255;
    cur_r = 32'h800F_422C;
    cur_t = 32'h8000_2400;

    set_regs(CountScaleRst, FiltBRst, FiltARst, WheelRadiusRst, FanBaseRst, FanGainRst,
             FanMaxRst);
    run_phase(PhaseItems);
    set_regs('0, '0, '0, '0, '0, '0, '0);
    run_phase(PhaseItems);
    set_regs('1, '1, '1, '1, '1, '1, '1);
    run_phase(PhaseItems);
    repeat (3) begin
      set_regs(20'($urandom_range(0, 20'hF_FFFF)), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_phase(PhaseItems);
    end
    // Closing stretch at full rate on both sides.
    set_regs(CountScaleRst, FiltBRst, FiltARst, WheelRadiusRst, FanBaseRst, FanGainRst,
             FanMaxRst);
    idling = 1'b0;
    run_phase(PhaseItems);

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d samples under %0d register settings; %0d words compared.",
             sent, settings, checked);
    $display("Saturated wheel speeds seen: %0d; mismatches: %0d.", saturated, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wsei_pkg.sv
hw/rtl/wsei_div.sv
hw/rtl/wheel_speed_estimator_iir_top.sv
verif/wheel_speed_estimator_iir_top_tb.sv
